// ===== rtl/core/pid_pkg.sv =====
`default_nettype none

package pid_pkg;

  localparam int unsigned SampleW = 10;
  localparam int unsigned ErrW    = SampleW + 1;
  localparam int unsigned DiffW   = ErrW + 1;
  localparam int unsigned GainW   = 16;
  localparam int unsigned ShiftW  = 4;
  localparam int unsigned IdxW    = 2;
  localparam int unsigned IntegW  = 48;
  localparam int unsigned DriveW  = 8;

  // Product widths: signed operand times a zero-extended unsigned gain.
  localparam int unsigned ProdW   = ErrW + GainW + 1;
  localparam int unsigned DerW    = DiffW + GainW + 1;
  // Integral increment before the period shift, with eight fraction bits added.
  localparam int unsigned IncrW   = ProdW + 8;
  // Derivative term after the left shift by up to fifteen places.
  localparam int unsigned DerShW  = DerW + (2 ** ShiftW) - 1;
  localparam int unsigned PdW     = DerShW + 1;
  // Q.16 total and its integer part.
  localparam int unsigned SumW    = PdW + 8 + 1;
  localparam int unsigned WholeW  = SumW - 16;

  localparam logic [GainW-1:0]  GainPropRst   = 16'd512;
  localparam logic [GainW-1:0]  GainIntegRst  = 16'd64;
  localparam logic [GainW-1:0]  GainDerivRst  = 16'd32;
  localparam logic [ShiftW-1:0] PeriodShiftRst = 4'd5;

  localparam logic [IntegW-1:0] IntegMax = {1'b0, {(IntegW-1){1'b1}}};
  localparam logic [IntegW-1:0] IntegMin = {1'b1, {(IntegW-1){1'b0}}};
  localparam logic [DriveW-1:0] DriveMax = {1'b0, {(DriveW-1){1'b1}}};
  localparam logic [DriveW-1:0] DriveMin = {1'b1, {(DriveW-1){1'b0}}};

  typedef enum logic [IdxW-1:0] {
    REG_GAIN_PROP    = 2'd0,
    REG_GAIN_INTEG   = 2'd1,
    REG_GAIN_DERIV   = 2'd2,
    REG_PERIOD_SHIFT = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [GainW-1:0]  gain_prop;
    logic [GainW-1:0]  gain_integ;
    logic [GainW-1:0]  gain_deriv;
    logic [ShiftW-1:0] period_shift;
  } cfg_t;

endpackage

`default_nettype wire

// ===== rtl/core/pid_cfg.sv =====
`default_nettype none

module pid_cfg (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [pid_pkg::IdxW-1:0]  cfg_idx_i,
  input  wire logic [pid_pkg::GainW-1:0] cfg_data_i,
  output pid_pkg::cfg_t                  cfg_o
);

  pid_pkg::cfg_t cfg_q;
  pid_pkg::cfg_t cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (pid_pkg::reg_idx_e'(cfg_idx_i))
        pid_pkg::REG_GAIN_PROP:    cfg_d.gain_prop    = cfg_data_i;
        pid_pkg::REG_GAIN_INTEG:   cfg_d.gain_integ   = cfg_data_i;
        pid_pkg::REG_GAIN_DERIV:   cfg_d.gain_deriv   = cfg_data_i;
        pid_pkg::REG_PERIOD_SHIFT: cfg_d.period_shift = cfg_data_i[pid_pkg::ShiftW-1:0];
        default:                   cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_prop    <= pid_pkg::GainPropRst;
      cfg_q.gain_integ   <= pid_pkg::GainIntegRst;
      cfg_q.gain_deriv   <= pid_pkg::GainDerivRst;
      cfg_q.period_shift <= pid_pkg::PeriodShiftRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== rtl/core/pid_front.sv =====
`default_nettype none

module pid_front (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire pid_pkg::cfg_t               cfg_i,
  input  wire logic                        valid_i,
  output logic                             ready_o,
  input  wire logic [pid_pkg::SampleW-1:0] reference_i,
  input  wire logic [pid_pkg::SampleW-1:0] measured_i,
  output logic                             valid_o,
  input  wire logic                        ready_i,
  output logic [pid_pkg::ProdW-1:0]        prod_int_o,
  output logic [pid_pkg::ProdW-1:0]        prod_prop_o,
  output logic [pid_pkg::DerW-1:0]         prod_der_o
);

  logic                        in_valid_q;
  logic [pid_pkg::SampleW-1:0] reference_q;
  logic [pid_pkg::SampleW-1:0] measured_q;
  logic                        prod_valid_q;
  logic [pid_pkg::ErrW-1:0]    prev_err_q;
  logic [pid_pkg::ProdW-1:0]   prod_int_q;
  logic [pid_pkg::ProdW-1:0]   prod_prop_q;
  logic [pid_pkg::DerW-1:0]    prod_der_q;

  logic                        in_ready;
  logic                        prod_ready;
  logic                        in_load;
  logic                        prod_load;
  logic [pid_pkg::ErrW-1:0]    err_d;
  logic [pid_pkg::DiffW-1:0]   diff;
  logic signed [pid_pkg::ProdW-1:0] prod_int_d;
  logic signed [pid_pkg::ProdW-1:0] prod_prop_d;
  logic signed [pid_pkg::DerW-1:0]  prod_der_d;

  assign prod_ready = !prod_valid_q || ready_i;
  assign in_ready   = !in_valid_q || prod_ready;
  assign in_load    = valid_i && in_ready;
  assign prod_load  = in_valid_q && prod_ready;

  assign err_d = {1'b0, reference_q} - {1'b0, measured_q};
  assign diff  = {err_d[pid_pkg::ErrW-1], err_d} - {prev_err_q[pid_pkg::ErrW-1], prev_err_q};

  // Integral uses the previous error, proportional the current, derivative the change.
  assign prod_int_d  = $signed(prev_err_q) * $signed({1'b0, cfg_i.gain_integ});
  assign prod_prop_d = $signed(err_d) * $signed({1'b0, cfg_i.gain_prop});
  assign prod_der_d  = $signed(diff) * $signed({1'b0, cfg_i.gain_deriv});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q   <= 1'b0;
      prod_valid_q <= 1'b0;
      prev_err_q   <= '0;
    end else begin
      if (in_ready) begin
        in_valid_q <= valid_i;
      end
      if (prod_ready) begin
        prod_valid_q <= in_valid_q;
      end
      if (prod_load) begin
        prev_err_q <= err_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      reference_q <= reference_i;
      measured_q  <= measured_i;
    end
    if (prod_load) begin
      prod_int_q  <= prod_int_d;
      prod_prop_q <= prod_prop_d;
      prod_der_q  <= prod_der_d;
    end
  end

  assign ready_o     = in_ready;
  assign valid_o     = prod_valid_q;
  assign prod_int_o  = prod_int_q;
  assign prod_prop_o = prod_prop_q;
  assign prod_der_o  = prod_der_q;

endmodule

`default_nettype wire

// ===== rtl/core/pid_integ.sv =====
`default_nettype none

module pid_integ (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic [pid_pkg::ShiftW-1:0] period_shift_i,
  input  wire logic                       valid_i,
  output logic                            ready_o,
  input  wire logic [pid_pkg::ProdW-1:0]  prod_int_i,
  input  wire logic [pid_pkg::ProdW-1:0]  prod_prop_i,
  input  wire logic [pid_pkg::DerW-1:0]   prod_der_i,
  output logic                            valid_o,
  input  wire logic                       ready_i,
  output logic [pid_pkg::IntegW-1:0]      integ_o,
  output logic [pid_pkg::PdW-1:0]         pd_o
);

  localparam int unsigned AccW = pid_pkg::IntegW + 1;

  logic                         valid_q;
  logic [pid_pkg::IntegW-1:0]   integ_q;
  logic [pid_pkg::IntegW-1:0]   integ_d;
  logic [pid_pkg::IntegW-1:0]   integ_out_q;
  logic [pid_pkg::PdW-1:0]      pd_q;
  logic [pid_pkg::PdW-1:0]      pd_d;

  logic                         ready;
  logic                         load;
  logic                         neg;
  logic [pid_pkg::IncrW-1:0]    scaled;
  logic [pid_pkg::IncrW-1:0]    mag;
  logic [pid_pkg::IncrW-1:0]    mag_sh;
  logic [pid_pkg::IncrW-1:0]    incr;
  logic [AccW-1:0]              acc;
  logic [pid_pkg::DerShW-1:0]   der_sh;

  assign ready = !valid_q || ready_i;
  assign load  = valid_i && ready;

  // Increment in Q.16: the product carries Q.8, so eight more fraction bits are
  // appended before the period shift, which truncates the magnitude.
  assign neg    = prod_int_i[pid_pkg::ProdW-1];
  assign scaled = {prod_int_i, 8'd0};
  assign mag    = neg ? (~scaled + 1'b1) : scaled;
  assign mag_sh = mag >> period_shift_i;
  assign incr   = neg ? (~mag_sh + 1'b1) : mag_sh;

  assign acc = {integ_q[pid_pkg::IntegW-1], integ_q}
             + {{(AccW-pid_pkg::IncrW){incr[pid_pkg::IncrW-1]}}, incr};

  always_comb begin
    if (acc[AccW-1] != acc[AccW-2]) begin
      integ_d = acc[AccW-1] ? pid_pkg::IntegMin : pid_pkg::IntegMax;
    end else begin
      integ_d = acc[pid_pkg::IntegW-1:0];
    end
  end

  assign der_sh = {{(pid_pkg::DerShW-pid_pkg::DerW){prod_der_i[pid_pkg::DerW-1]}}, prod_der_i}
                << period_shift_i;
  assign pd_d   = {{(pid_pkg::PdW-pid_pkg::ProdW){prod_prop_i[pid_pkg::ProdW-1]}}, prod_prop_i}
                + {der_sh[pid_pkg::DerShW-1], der_sh};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      integ_q <= '0;
    end else begin
      if (ready) begin
        valid_q <= valid_i;
      end
      if (load) begin
        integ_q <= integ_d;
      end
    end
  end

  // The updated sum travels with its item, since the next item may change it.
  always_ff @(posedge clk_i) begin
    if (load) begin
      integ_out_q <= integ_d;
      pd_q        <= pd_d;
    end
  end

  assign ready_o = ready;
  assign valid_o = valid_q;
  assign integ_o = integ_out_q;
  assign pd_o    = pd_q;

endmodule

`default_nettype wire

// ===== rtl/core/pid_out.sv =====
`default_nettype none

module pid_out (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        valid_i,
  output logic                             ready_o,
  input  wire logic [pid_pkg::IntegW-1:0]  integ_i,
  input  wire logic [pid_pkg::PdW-1:0]     pd_i,
  output logic                             valid_o,
  input  wire logic                        ready_i,
  output logic [pid_pkg::DriveW-1:0]       drive_o,
  output logic                             saturated_o
);

  logic                         valid_q;
  logic [pid_pkg::DriveW-1:0]   drive_q;
  logic [pid_pkg::DriveW-1:0]   drive_d;
  logic                         sat_q;
  logic                         sat_d;

  logic                         ready;
  logic                         load;
  logic [pid_pkg::SumW-1:0]     total;
  logic                         round_up;
  logic [pid_pkg::WholeW-1:0]   whole;
  logic                         over;
  logic                         under;

  assign ready = !valid_q || ready_i;
  assign load  = valid_i && ready;

  assign total = {{(pid_pkg::SumW-pid_pkg::IntegW){integ_i[pid_pkg::IntegW-1]}}, integ_i}
               + {pd_i[pid_pkg::PdW-1], pd_i, 8'd0};

  // Dropping the fraction floors; a negative value with a fraction moves up by one.
  assign round_up = total[pid_pkg::SumW-1] && (|total[15:0]);
  assign whole    = total[pid_pkg::SumW-1:16] + {{(pid_pkg::WholeW-1){1'b0}}, round_up};

  assign over  = !whole[pid_pkg::WholeW-1] && (|whole[pid_pkg::WholeW-2:pid_pkg::DriveW-1]);
  assign under =  whole[pid_pkg::WholeW-1] && !(&whole[pid_pkg::WholeW-2:pid_pkg::DriveW-1]);

  always_comb begin
    drive_d = whole[pid_pkg::DriveW-1:0];
    sat_d   = 1'b0;
    if (over) begin
      drive_d = pid_pkg::DriveMax;
      sat_d   = 1'b1;
    end else if (under) begin
      drive_d = pid_pkg::DriveMin;
      sat_d   = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      drive_q <= drive_d;
      sat_q   <= sat_d;
    end
  end

  assign ready_o     = ready;
  assign valid_o     = valid_q;
  assign drive_o     = drive_q;
  assign saturated_o = sat_q;

endmodule

`default_nettype wire

// ===== rtl/core/pid_controller_step.sv =====
// Each accepted pair passes the input, product, integrator and output registers in order.
// Throughput: one sample pair per cycle; four register stages (input, products,
// integrator, output) each hold one item and stall together when the output is not taken.
// Reset: gains return to 2.0, 0.25 and 0.125, the period shift to 5, and the integrator
// and the stored previous error are cleared; the pipeline is emptied.
`default_nettype none

module pid_controller_step (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [pid_pkg::IdxW-1:0]    cfg_idx_i,
  input  wire logic [pid_pkg::GainW-1:0]   cfg_data_i,
  input  wire logic                        s_axis_tvalid,
  output logic                             s_axis_tready,
  input  wire logic [23:0]                 s_axis_tdata,  // reference [9:0], measured [19:10]
  output logic                             m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  output logic [7:0]                       m_axis_tdata,  // drive [7:0]
  output logic                             m_axis_tuser   // saturated [0]
);

  pid_pkg::cfg_t                 cfg;
  logic                          prod_valid;
  logic                          prod_ready;
  logic [pid_pkg::ProdW-1:0]     prod_int;
  logic [pid_pkg::ProdW-1:0]     prod_prop;
  logic [pid_pkg::DerW-1:0]      prod_der;
  logic                          sum_valid;
  logic                          sum_ready;
  logic [pid_pkg::IntegW-1:0]    integ;
  logic [pid_pkg::PdW-1:0]       pd;

  pid_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  pid_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .valid_i     (s_axis_tvalid),
    .ready_o     (s_axis_tready),
    .reference_i (s_axis_tdata[9:0]),
    .measured_i  (s_axis_tdata[19:10]),
    .valid_o     (prod_valid),
    .ready_i     (prod_ready),
    .prod_int_o  (prod_int),
    .prod_prop_o (prod_prop),
    .prod_der_o  (prod_der)
  );

  pid_integ u_integ (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .period_shift_i (cfg.period_shift),
    .valid_i        (prod_valid),
    .ready_o        (prod_ready),
    .prod_int_i     (prod_int),
    .prod_prop_i    (prod_prop),
    .prod_der_i     (prod_der),
    .valid_o        (sum_valid),
    .ready_i        (sum_ready),
    .integ_o        (integ),
    .pd_o           (pd)
  );

  pid_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (sum_valid),
    .ready_o     (sum_ready),
    .integ_i     (integ),
    .pd_i        (pd),
    .valid_o     (m_axis_tvalid),
    .ready_i     (m_axis_tready),
    .drive_o     (m_axis_tdata),
    .saturated_o (m_axis_tuser)
  );

endmodule

`default_nettype wire
